// ----- rtl/byte_stream_instruction_decoder_top_defines.svh -----
// assertion macros for the 8080 byte stream decoder
`ifndef BYTE_STREAM_INSTRUCTION_DECODER_TOP_DEFINES_SVH
`define BYTE_STREAM_INSTRUCTION_DECODER_TOP_DEFINES_SVH

// same-cycle implication, sampled on clk, off during reset
`define BSID_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, sampled on clk, off during reset
`define BSID_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- rtl/bsid_pkg.sv -----
// types, codes and decode functions for the 8080 byte stream decoder
`default_nettype none

package bsid_pkg;

	localparam logic [3:0] NONE_OPERAND = 4'd13;
	localparam logic [3:0] PSW_OPERAND  = 4'd12;
	localparam logic [3:0] PAIR_BASE    = 4'd8;

	localparam logic [5:0] M_NOP  = 6'd0;
	localparam logic [5:0] M_LXI  = 6'd1;
	localparam logic [5:0] M_STAX = 6'd2;
	localparam logic [5:0] M_SHLD = 6'd3;
	localparam logic [5:0] M_STA  = 6'd4;
	localparam logic [5:0] M_INX  = 6'd5;
	localparam logic [5:0] M_INR  = 6'd6;
	localparam logic [5:0] M_DCR  = 6'd7;
	localparam logic [5:0] M_MVI  = 6'd8;
	localparam logic [5:0] M_DAD  = 6'd13;
	localparam logic [5:0] M_LDAX = 6'd14;
	localparam logic [5:0] M_LHLD = 6'd15;
	localparam logic [5:0] M_LDA  = 6'd16;
	localparam logic [5:0] M_DCX  = 6'd17;
	localparam logic [5:0] M_MOV  = 6'd22;
	localparam logic [5:0] M_HLT  = 6'd23;
	localparam logic [5:0] M_RCC  = 6'd32;
	localparam logic [5:0] M_POP  = 6'd33;
	localparam logic [5:0] M_JCC  = 6'd34;
	localparam logic [5:0] M_CCC  = 6'd39;
	localparam logic [5:0] M_PUSH = 6'd40;
	localparam logic [5:0] M_RST  = 6'd49;
	localparam logic [5:0] M_RET  = 6'd50;
	localparam logic [5:0] M_PCHL = 6'd51;
	localparam logic [5:0] M_SPHL = 6'd52;
	localparam logic [5:0] M_CALL = 6'd56;

	localparam logic [7:0] OP_HLT = 8'h76;

	localparam logic [1:0] LEN_ONE   = 2'd1;
	localparam logic [1:0] LEN_TWO   = 2'd2;
	localparam logic [1:0] LEN_THREE = 2'd3;

	localparam logic [5:0] ROT_CLASS [0:7] = '{6'd9, 6'd18, 6'd10, 6'd19,
		6'd11, 6'd20, 6'd12, 6'd21};
	localparam logic [5:0] ALU_CLASS [0:7] = '{6'd24, 6'd25, 6'd26, 6'd27,
		6'd28, 6'd29, 6'd30, 6'd31};
	localparam logic [5:0] IMM_CLASS [0:7] = '{6'd41, 6'd42, 6'd43, 6'd44,
		6'd45, 6'd46, 6'd47, 6'd48};
	localparam logic [5:0] MEM_CLASS [0:7] = '{M_STAX, M_LDAX, M_STAX, M_LDAX,
		M_SHLD, M_LHLD, M_STA, M_LDA};
	localparam logic [5:0] MISC_CLASS [0:7] = '{6'd35, 6'd35, 6'd36, 6'd53,
		6'd37, 6'd54, 6'd38, 6'd55};

	typedef struct packed {
		logic [5:0] mnemonic;
		logic [3:0] first_operand;
		logic [3:0] second_operand;
		logic [2:0] cond_or_vector;
	} dec_t;

	function automatic logic [1:0] op_length(input logic [7:0] op);
		logic [2:0] z;
		logic [2:0] y;
		logic [1:0] len;
		z = op[2:0];
		y = op[5:3];
		len = LEN_ONE;
		if (op[7:6] == 2'b00) begin
			if (z == 3'd1 && !y[0])
				len = LEN_THREE;
			else if (z == 3'd2 && y[2])
				len = LEN_THREE;
			else if (z == 3'd6)
				len = LEN_TWO;
		end else if (op[7:6] == 2'b11) begin
			case (z)
				3'd2, 3'd4: len = LEN_THREE;
				3'd3: begin
					if (y <= 3'd1)
						len = LEN_THREE;
					else if (y <= 3'd3)
						len = LEN_TWO;
				end
				3'd5: begin
					if (y[0])
						len = LEN_THREE;
				end
				3'd6: len = LEN_TWO;
				default: len = LEN_ONE;
			endcase
		end
		return len;
	endfunction

	function automatic dec_t decode(input logic [7:0] op);
		logic [2:0] z;
		logic [2:0] y;
		logic [1:0] p;
		logic [3:0] pair;
		logic [3:0] stack_pair;
		dec_t d;
		z = op[2:0];
		y = op[5:3];
		p = op[5:4];
		pair = PAIR_BASE | {2'b00, p};
		stack_pair = (p == 2'd3) ? PSW_OPERAND : pair;
		d.mnemonic = M_NOP;
		d.first_operand = NONE_OPERAND;
		d.second_operand = NONE_OPERAND;
		d.cond_or_vector = 3'd0;
		case (op[7:6])
			2'b00: begin
				case (z)
					3'd0: d.mnemonic = M_NOP;
					3'd1: begin
						d.mnemonic = y[0] ? M_DAD : M_LXI;
						d.first_operand = pair;
					end
					3'd2: begin
						d.mnemonic = MEM_CLASS[y];
						if (!y[2])
							d.first_operand = pair;
					end
					3'd3: begin
						d.mnemonic = y[0] ? M_DCX : M_INX;
						d.first_operand = pair;
					end
					3'd4: begin
						d.mnemonic = M_INR;
						d.first_operand = {1'b0, y};
					end
					3'd5: begin
						d.mnemonic = M_DCR;
						d.first_operand = {1'b0, y};
					end
					3'd6: begin
						d.mnemonic = M_MVI;
						d.first_operand = {1'b0, y};
					end
					default: d.mnemonic = ROT_CLASS[y];
				endcase
			end
			2'b01: begin
				if (op == OP_HLT) begin
					d.mnemonic = M_HLT;
				end else begin
					d.mnemonic = M_MOV;
					d.first_operand = {1'b0, y};
					d.second_operand = {1'b0, z};
				end
			end
			2'b10: begin
				d.mnemonic = ALU_CLASS[y];
				d.first_operand = {1'b0, z};
			end
			default: begin
				case (z)
					3'd0: begin
						d.mnemonic = M_RCC;
						d.cond_or_vector = y;
					end
					3'd1: begin
						if (!y[0]) begin
							d.mnemonic = M_POP;
							d.first_operand = stack_pair;
						end else if (y == 3'd5) begin
							d.mnemonic = M_PCHL;
						end else if (y == 3'd7) begin
							d.mnemonic = M_SPHL;
						end else begin
							d.mnemonic = M_RET;
						end
					end
					3'd2: begin
						d.mnemonic = M_JCC;
						d.cond_or_vector = y;
					end
					3'd3: d.mnemonic = MISC_CLASS[y];
					3'd4: begin
						d.mnemonic = M_CCC;
						d.cond_or_vector = y;
					end
					3'd5: begin
						if (!y[0]) begin
							d.mnemonic = M_PUSH;
							d.first_operand = stack_pair;
						end else begin
							d.mnemonic = M_CALL;
						end
					end
					3'd6: d.mnemonic = IMM_CLASS[y];
					default: begin
						d.mnemonic = M_RST;
						d.cond_or_vector = y;
					end
				endcase
			end
		endcase
		return d;
	endfunction

endpackage

`default_nettype wire

// ----- rtl/bsid_if.sv -----
// byte and result channel interfaces for the 8080 byte stream decoder
`default_nettype none

interface bsid_byte_if;
	logic       valid;
	logic       ready;
	logic [7:0] code_byte;

	modport source (output valid, output code_byte, input ready);
	modport sink (input valid, input code_byte, output ready);
endinterface

interface bsid_result_if;
	logic        valid;
	logic        ready;
	logic [7:0]  opcode;
	logic [5:0]  mnemonic;
	logic [3:0]  first_operand;
	logic [3:0]  second_operand;
	logic [2:0]  cond_or_vector;
	logic [15:0] immediate;
	logic [1:0]  length;

	modport source (output valid, output opcode, output mnemonic, output first_operand,
		output second_operand, output cond_or_vector, output immediate, output length,
		input ready);
	modport sink (input valid, input opcode, input mnemonic, input first_operand,
		input second_operand, input cond_or_vector, input immediate, input length,
		output ready);
endinterface

`default_nettype wire

// ----- rtl/byte_stream_instruction_decoder_top.sv -----
// 8080 instruction decoder over a code byte stream: a byte register, decode, a result register
// a completed instruction passes from the byte register through decode into the result register
// throughput: one byte per cycle unless a completing byte stalls, set by the single decode stage and result register
// while a result waits, a byte that completes an instruction stalls in the byte register
// reset clears the valid flags and the operand byte counter; a partial instruction is dropped
`default_nettype none
`include "byte_stream_instruction_decoder_top_defines.svh"

module byte_stream_instruction_decoder_top (
	input  wire            clk,
	input  wire            arst_n,
	bsid_byte_if.sink      code,
	bsid_result_if.source  result
);

	localparam logic [1:0] NEED_NONE   = 2'd0;
	localparam logic [1:0] NEED_ONE    = 2'd1;
	localparam logic [1:0] NEED_TWO    = 2'd2;
	localparam logic [1:0] NEED_UNUSED = 2'd3;

	logic        valid_s1;
	logic [7:0]  byte_s1;
	logic [1:0]  need_q;
	logic [7:0]  held_op_q;
	logic [7:0]  held_low_q;
	logic        out_valid_q;

	logic [7:0]        op_sel;
	logic [1:0]        len_sel;
	bsid_pkg::dec_t    dec;
	logic              produces;
	logic              out_free;
	logic              s1_go;
	logic [15:0]       imm;

	assign op_sel   = (need_q == NEED_ONE) ? held_op_q : byte_s1;
	assign len_sel  = bsid_pkg::op_length(op_sel);
	assign dec      = bsid_pkg::decode(op_sel);
	assign produces = (need_q == NEED_ONE) || (need_q != NEED_TWO && len_sel == bsid_pkg::LEN_ONE);
	assign out_free = !out_valid_q || result.ready;
	assign s1_go    = valid_s1 && (!produces || out_free);
	assign code.ready = !valid_s1 || s1_go;

	always_comb begin
		imm = 16'd0;
		if (need_q == NEED_ONE) begin
			if (len_sel == bsid_pkg::LEN_THREE)
				imm = {byte_s1, held_low_q};
			else
				imm = {8'd0, byte_s1};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (code.valid && code.ready) begin
			valid_s1 <= 1'b1;
		end else if (s1_go) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (code.valid && code.ready)
			byte_s1 <= code.code_byte;
	end

	// operand gathering; the unused counter code 3 behaves as awaiting an opcode
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			need_q     <= NEED_NONE;
			held_op_q  <= 8'd0;
			held_low_q <= 8'd0;
		end else if (s1_go) begin
			case (need_q)
				NEED_TWO: begin
					held_low_q <= byte_s1;
					need_q     <= NEED_ONE;
				end
				NEED_ONE: need_q <= NEED_NONE;
				default: begin
					if (len_sel != bsid_pkg::LEN_ONE) begin
						held_op_q  <= byte_s1;
						held_low_q <= 8'd0;
						need_q     <= len_sel - 2'd1;
					end else begin
						need_q <= NEED_NONE;
					end
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (s1_go && produces) begin
			out_valid_q <= 1'b1;
		end else if (result.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_go && produces) begin
			result.opcode         <= op_sel;
			result.mnemonic       <= dec.mnemonic;
			result.first_operand  <= dec.first_operand;
			result.second_operand <= dec.second_operand;
			result.cond_or_vector <= dec.cond_or_vector;
			result.immediate      <= imm;
			result.length         <= len_sel;
		end
	end

	assign result.valid = out_valid_q;

	`BSID_ASSERT_NOW(a_counter_code, 1'b1, need_q != NEED_UNUSED, "operand counter holds unused code")
	`BSID_ASSERT_NEXT(a_low_then_high, s1_go && need_q == NEED_TWO, need_q == NEED_ONE,
		"low operand byte not followed by awaiting high byte")
	`BSID_ASSERT_NEXT(a_result_loaded, s1_go && produces, out_valid_q,
		"completed instruction did not reach result register")
	`BSID_ASSERT_NOW(a_short_no_imm, result.valid && result.length == bsid_pkg::LEN_ONE,
		result.immediate == 16'd0, "one-byte instruction carries an immediate")
	`BSID_ASSERT_NOW(a_mov_only_src, result.valid && result.mnemonic != bsid_pkg::M_MOV,
		result.second_operand == bsid_pkg::NONE_OPERAND, "source operand set outside MOV")

endmodule

`default_nettype wire
